// File: rtl/ptq_pkg.sv
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types and codes for the sorted priority task queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ptq_pkg;

    localparam int ID_W  = 16;
    localparam int PRI_W = 8;

    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_POP    = 2'd1,
        K_REMOVE = 2'd2,
        K_VIEW   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ADD,
        CELL_POP,
        CELL_REMOVE,
        CELL_ROTATE
    } t_cell_op;

    typedef enum logic {
        S_IDLE,
        S_VIEW
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } t_entry;

    typedef struct packed {
        t_cell_op         op;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: rtl/priority_task_queue.sv
// A result is registered in the cycle after its request is accepted.
// A new request is taken every cycle while the result register drains.
// View emits one entry per cycle while the receiver takes them, rotating
// the cell chain; the next request is taken once the final entry is loaded.
// Reset (synchronous) empties the queue; stored ids and priorities are not
// cleared.
// ----------------------------------------------------------------------------
// priority_task_queue
// Sorted priority queue built from a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_queue #(
    parameter int CAPACITY = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [23:0] i_s_tdata,   // task_id[15:0], priority_req[23:16]
    input  wire  [1:0]  i_s_tuser,   // kind[1:0]
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,   // entry_id[15:0], entry_priority[23:16]
    output logic [1:0]  o_m_tuser,   // status[1:0]
    output logic        o_m_tlast
);
    import ptq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_entry          cell_q [CAPACITY];
    logic            cell_ge [CAPACITY];
    logic            hit [CAPACITY+1];
    logic [CAPACITY-1:0] take;
    t_cell_ctl       ctl;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_ov, n_ov;
    t_status          r_status, n_status;
    logic [ID_W-1:0]  r_id, n_id;
    logic [PRI_W-1:0] r_pri, n_pri;
    logic             r_last, n_last;

    logic   out_free;
    logic   accept;
    logic   full;
    logic   empty;
    t_entry found;
    t_kind  kind;

    assign hit[0] = 1'b0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_entry left_e;
        t_entry right_e;
        logic   left_ge;
        if (k == 0) begin : g_first
            assign left_e  = '0;
            assign left_ge = 1'b1;
        end else begin : g_mid
            assign left_e  = cell_q[k-1];
            assign left_ge = cell_ge[k-1];
        end
        if (k == CAPACITY - 1) begin : g_end
            assign right_e = '0;
        end else begin : g_inner
            assign right_e = cell_q[k+1];
        end
        ptq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_left    (left_e),
            .i_left_ge (left_ge),
            .i_right   (right_e),
            .i_head    (cell_q[0]),
            .i_hit     (hit[k]),
            .o_entry   (cell_q[k]),
            .o_ge      (cell_ge[k]),
            .o_hit     (hit[k+1]),
            .o_take    (take[k])
        );
    end

    always_comb begin
        found = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            found = found | (take[k] ? cell_q[k] : '0);
        end
    end

    assign kind       = t_kind'(i_s_tuser);
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign empty      = (r_count == '0);
    assign out_free   = !r_ov || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        n_ov     = r_ov && !i_m_tready;
        n_status = r_status;
        n_id     = r_id;
        n_pri    = r_pri;
        n_last   = r_last;
        ctl.op   = CELL_HOLD;
        ctl.id   = i_s_tdata[15:0];
        ctl.pri  = i_s_tdata[23:16];
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ov     = 1'b1;
                    n_last   = 1'b1;
                    n_status = ST_OK;
                    n_id     = '0;
                    n_pri    = '0;
                    case (kind)
                        K_ADD: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                ctl.op  = CELL_ADD;
                                n_count = r_count + 1'b1;
                            end
                        end
                        K_POP: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                ctl.op  = CELL_POP;
                                n_id    = cell_q[0].id;
                                n_pri   = cell_q[0].pri;
                                n_count = r_count - 1'b1;
                            end
                        end
                        K_REMOVE: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else if (hit[CAPACITY]) begin
                                ctl.op  = CELL_REMOVE;
                                n_id    = found.id;
                                n_pri   = found.pri;
                                n_count = r_count - 1'b1;
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        K_VIEW: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                ctl.op = CELL_ROTATE;
                                n_id   = cell_q[0].id;
                                n_pri  = cell_q[0].pri;
                                n_left = r_count - 1'b1;
                                n_last = (r_count == CNT_W'(1));
                                if (r_count != CNT_W'(1)) begin
                                    n_state = S_VIEW;
                                end
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_VIEW: begin
                if (out_free) begin
                    ctl.op   = CELL_ROTATE;
                    n_ov     = 1'b1;
                    n_status = ST_OK;
                    n_id     = cell_q[0].id;
                    n_pri    = cell_q[0].pri;
                    n_left   = r_left - 1'b1;
                    n_last   = (r_left == CNT_W'(1));
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_id     <= n_id;
        r_pri    <= n_pri;
        r_last   <= n_last;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_pri, r_id};
    assign o_m_tuser  = r_status;
    assign o_m_tlast  = r_last;

    a_head_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_q[0].valid == (r_count != '0))
        else $error("head valid bit disagrees with entry count");

    a_tail_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_q[CAPACITY-1].valid == (r_count == CNT_W'(CAPACITY)))
        else $error("tail valid bit disagrees with full queue");

    a_one_take : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(take))
        else $error("more than one cell selected for removal");

    a_view_left : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VIEW) |-> (r_left != '0 && r_left < r_count))
        else $error("view counter out of range");

    a_count_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

endmodule

`default_nettype wire

// File: rtl/ptq_cell.sv
// ----------------------------------------------------------------------------
// ptq_cell
// One slot of the queue: holds an entry, compares it with the request and
// keeps it or takes the request, the left or right neighbor's or head entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire ptq_pkg::t_cell_ctl  i_ctl,
    input  wire ptq_pkg::t_entry     i_left,
    input  wire                      i_left_ge,
    input  wire ptq_pkg::t_entry     i_right,
    input  wire ptq_pkg::t_entry     i_head,
    input  wire                      i_hit,
    output ptq_pkg::t_entry          o_entry,
    output logic                     o_ge,
    output logic                     o_hit,
    output logic                     o_take
);
    import ptq_pkg::*;

    logic             r_valid;
    logic [ID_W-1:0]  r_id;
    logic [PRI_W-1:0] r_pri;
    t_entry           cur;
    t_entry           n_entry;
    logic             match;

    assign cur    = '{valid: r_valid, id: r_id, pri: r_pri};
    assign o_entry = cur;
    assign o_ge   = r_valid && (r_pri >= i_ctl.pri);
    assign match  = r_valid && (r_id == i_ctl.id);
    assign o_hit  = i_hit | match;
    assign o_take = match & ~i_hit;

    always_comb begin
        n_entry = cur;
        case (i_ctl.op)
            CELL_ADD: begin
                if (!o_ge) begin
                    if (i_left_ge) begin
                        n_entry = '{valid: 1'b1, id: i_ctl.id, pri: i_ctl.pri};
                    end else begin
                        n_entry = i_left;
                    end
                end
            end
            CELL_POP: begin
                n_entry = i_right;
            end
            CELL_REMOVE: begin
                if (o_hit) begin
                    n_entry = i_right;
                end
            end
            CELL_ROTATE: begin
                if (r_valid) begin
                    n_entry = i_right.valid ? i_right : i_head;
                end
            end
            default: begin
                n_entry = cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_entry.id;
        r_pri <= n_entry.pri;
    end

endmodule

`default_nettype wire

// File: tb/sv/ptq_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// ptq_scoreboard_pkg
// Tracks the expected queue contents and checks each result of the
// sorted priority task queue against the oldest pending expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptq_scoreboard_pkg;

    import ptq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_PRINTED = 30;

    typedef struct {
        t_status          status;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        logic             last;
    } t_queue_result;

    class queue_scoreboard;

        logic [ID_W-1:0]  held_ids[$];
        logic [PRI_W-1:0] held_pris[$];
        t_queue_result    pending_results[$];
        int               errors;

        function new();
            errors = 0;
        endfunction

        function void push_result(t_status st, logic [ID_W-1:0] id,
                                  logic [PRI_W-1:0] pri, logic last);
            t_queue_result r;
            r.status = st;
            r.id     = id;
            r.pri    = pri;
            r.last   = last;
            pending_results.push_back(r);
        endfunction

        function int held_count();
            return held_ids.size();
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // random id of a stored entry, or any id when the queue is empty
        function logic [ID_W-1:0] pick_held_id();
            if (held_ids.size() == 0)
                return ID_W'($urandom);
            return held_ids[$urandom_range(0, held_ids.size() - 1)];
        endfunction

        function void note_request(t_kind kind, logic [ID_W-1:0] id,
                                   logic [PRI_W-1:0] pri);
            int pos;
            case (kind)
                K_ADD: begin
                    if (held_ids.size() >= QUEUE_DEPTH) begin
                        push_result(ST_FULL, '0, '0, 1'b1);
                    end else begin
                        pos = 0;
                        while (pos < held_pris.size() && held_pris[pos] >= pri)
                            pos++;
                        held_ids.insert(pos, id);
                        held_pris.insert(pos, pri);
                        push_result(ST_OK, '0, '0, 1'b1);
                    end
                end
                K_POP: begin
                    if (held_ids.size() == 0) begin
                        push_result(ST_EMPTY, '0, '0, 1'b1);
                    end else begin
                        push_result(ST_OK, held_ids[0], held_pris[0], 1'b1);
                        held_ids.delete(0);
                        held_pris.delete(0);
                    end
                end
                K_REMOVE: begin
                    if (held_ids.size() == 0) begin
                        push_result(ST_EMPTY, '0, '0, 1'b1);
                    end else begin
                        pos = 0;
                        while (pos < held_ids.size() && held_ids[pos] != id)
                            pos++;
                        if (pos == held_ids.size()) begin
                            push_result(ST_NOT_FOUND, '0, '0, 1'b1);
                        end else begin
                            push_result(ST_OK, held_ids[pos], held_pris[pos], 1'b1);
                            held_ids.delete(pos);
                            held_pris.delete(pos);
                        end
                    end
                end
                default: begin
                    if (held_ids.size() == 0) begin
                        push_result(ST_EMPTY, '0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < held_ids.size(); i++)
                            push_result(ST_OK, held_ids[i], held_pris[i],
                                        i == held_ids.size() - 1);
                    end
                end
            endcase
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [1:0] st, logic [ID_W-1:0] id,
                          logic [PRI_W-1:0] pri, logic last);
            t_queue_result exp;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result status=%0d id=%h pri=%h last=%b",
                                 st, id, pri, last));
            end else begin
                exp = pending_results.pop_front();
                if (st !== exp.status)
                    report($sformatf("status %0d, want %s", st, exp.status.name()));
                if (id !== exp.id)
                    report($sformatf("entry_id %h, want %h", id, exp.id));
                if (pri !== exp.pri)
                    report($sformatf("entry_priority %h, want %h", pri, exp.pri));
                if (last !== exp.last)
                    report($sformatf("last %b, want %b", last, exp.last));
            end
        endtask

    endclass

endpackage

// File: tb/sv/priority_task_queue_test.sv
// ----------------------------------------------------------------------------
// priority_task_queue_test
// Drives add, pop, remove and view requests into the sorted priority task
// queue under random sender gaps and receiver stalls, and checks every
// result against a scoreboard that tracks the queue contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_task_queue_test;

    import ptq_pkg::*;
    import ptq_scoreboard_pkg::*;

    localparam int RANDOM_ITEMS = 90;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // task_id[15:0], priority_req[23:16]
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // entry_id[15:0], entry_priority[23:16]
    logic [1:0]  m_tuser;   // status[1:0]
    logic        m_tlast;

    queue_scoreboard sb;
    int              burst_left;
    int              cycle_count;
    logic            hold_req;
    logic            hold_off;
    logic [8:0]      rx_phase;

    priority_task_queue u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        sb    = new();
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** priority_task_queue: FAILED **");
            $finish;
        end
    end

    // receiver: cycle through always-ready, random and sparse patterns
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_phase <= '0;
            m_tready <= 1'b0;
        end else begin
            rx_phase <= rx_phase + 1'b1;
            if (hold_off) begin
                m_tready <= 1'b0;
            end else begin
                case (rx_phase[8:7])
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= $urandom_range(0, 1);
                    2'd2: m_tready <= (rx_phase[1:0] == 2'd0);
                    default: m_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[15:0], m_tdata[23:16], m_tlast);
    end

    // long receiver hold-off while the sender keeps offering requests
    initial begin
        hold_off = 1'b0;
        wait (hold_req === 1'b1);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic send_request(t_kind kind, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {pri, id};
        s_tuser  <= kind;
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(kind, id, pri);
    endtask

    task automatic send_random(t_mix mix, int count);
        int               roll;
        t_kind            kind;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:  kind = t_kind'((roll < 85) ? K_ADD : (roll < 90) ? K_POP :
                                          (roll < 94) ? K_REMOVE : K_VIEW);
                MIX_DRAIN: kind = t_kind'((roll < 15) ? K_ADD : (roll < 55) ? K_POP :
                                          (roll < 90) ? K_REMOVE : K_VIEW);
                default:   kind = t_kind'((roll < 40) ? K_ADD : (roll < 60) ? K_POP :
                                          (roll < 85) ? K_REMOVE : K_VIEW);
            endcase
            id  = ($urandom_range(0, 1) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 7));
            pri = ($urandom_range(0, 1) == 0) ? PRI_W'($urandom) : PRI_W'($urandom_range(0, 3));
            if (kind == K_REMOVE && $urandom_range(0, 9) < 7)
                id = sb.pick_held_id();
            send_request(kind, id, pri);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = K_ADD;
        hold_req    = 1'b0;
        cycle_count = 0;
        burst_left  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(K_VIEW,   16'h0000, 8'h00);
        send_request(K_POP,    16'h0000, 8'h00);
        send_request(K_REMOVE, 16'hFFFF, 8'hFF);
        send_request(K_ADD,    16'h0000, 8'hFF);
        send_request(K_ADD,    16'hFFFF, 8'h00);
        send_request(K_ADD,    16'hA5A5, 8'hFF);
        send_request(K_ADD,    16'hFFFF, 8'h80);
        send_request(K_ADD,    16'h5A5A, 8'h00);
        send_request(K_VIEW,   16'h1234, 8'h55);
        send_request(K_REMOVE, 16'hFFFF, 8'h00);
        send_request(K_REMOVE, 16'h1357, 8'h00);
        send_request(K_POP,    16'h0000, 8'h00);
        send_request(K_ADD,    16'h5A5A, 8'h01);
        send_request(K_VIEW,   16'h0000, 8'h00);
        send_request(K_REMOVE, 16'h5A5A, 8'h00);
        send_request(K_POP,    16'h0000, 8'h00);
        send_request(K_POP,    16'h0000, 8'h00);
        send_request(K_POP,    16'h0000, 8'h00);
        send_request(K_POP,    16'h0000, 8'h00);
        send_request(K_REMOVE, 16'h0000, 8'h00);
        send_request(K_VIEW,   16'hFFFF, 8'hFF);

        hold_req <= 1'b1;
        send_random(MIX_FILL, 30);
        send_random(MIX_DRAIN, 25);
        send_random(MIX_FILL, 25);
        send_random(MIX_EVEN, RANDOM_ITEMS - 80);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** priority_task_queue: PASSED **");
        end else begin
            $display("** priority_task_queue: FAILED **");
        end
        $finish;
    end

endmodule
